@@ rtl/core/kvt_pkg.sv @@
package kvt_pkg;

	localparam int ACTION_W  = 3;
	localparam int INDEX_W   = 4;
	localparam int COUNT_W   = 5;
	localparam int CAP_W     = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request actions
	localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_UPDATE = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_UPSERT = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_ERASE  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_READ   = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_RDIDX,
		ST_RDWAIT,
		ST_DONE
	} kvt_state_t;

endpackage

@@ rtl/core/kvt_store.sv @@
module kvt_store #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int AW         = 4
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [KEY_BITS-1:0]   rd_key,
	output logic [VALUE_BITS-1:0] rd_value,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [KEY_BITS-1:0]   wr_key,
	input  logic [VALUE_BITS-1:0] wr_value
);

	localparam int PW = KEY_BITS + VALUE_BITS;

	logic [PW-1:0] mem_q [ENTRIES];
	logic [PW-1:0] rd_data_q;

	// write one pair
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_key, wr_value};
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_key   = rd_data_q[PW-1:VALUE_BITS];
	assign rd_value = rd_data_q[VALUE_BITS-1:0];

endmodule

@@ rtl/core/kvt_seq.sv @@
module kvt_seq #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int AW         = 4,
	parameter int CW         = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [kvt_pkg::ACTION_W-1:0]  action,
	input  logic [KEY_BITS-1:0]           key,
	input  logic [VALUE_BITS-1:0]         value,
	input  logic [kvt_pkg::INDEX_W-1:0]   index,
	input  logic [kvt_pkg::CAP_W-1:0]     capacity,
	output logic                          busy,
	output logic                          done,
	output logic                          ok,
	output logic [KEY_BITS-1:0]           found_key,
	output logic [VALUE_BITS-1:0]         found_value,
	output logic [CW-1:0]                 count,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	input  logic [KEY_BITS-1:0]           rd_key,
	input  logic [VALUE_BITS-1:0]         rd_value,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [KEY_BITS-1:0]           wr_key,
	output logic [VALUE_BITS-1:0]         wr_value
);

	import kvt_pkg::*;

	localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

	kvt_state_t state_q, state_d;
	logic [ACTION_W-1:0]   act_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [INDEX_W-1:0]    idx_q;
	logic [CW-1:0]         ptr_q, ptr_d;
	logic                  pend_q, pend_d;
	logic [AW-1:0]         pend_addr_q, pend_addr_d;
	logic [CW-1:0]         count_q, count_d;
	logic                  ok_q, ok_d;
	logic [KEY_BITS-1:0]   fk_q, fk_d;
	logic [VALUE_BITS-1:0] fv_q, fv_d;
	logic                  hit;
	logic                  full;
	logic [LW-1:0]         idx_ext;
	logic                  accept;

	assign accept  = start && (state_q == ST_IDLE);
	assign hit     = pend_q && (rd_key == key_q);
	assign full    = (count_q >= CW'(ENTRIES)) || (LW'(count_q) >= LW'(capacity));
	assign idx_ext = LW'(idx_q);

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
		end
	end

	// request and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			key_q <= key;
			val_q <= value;
			idx_q <= index;
		end
		ptr_q       <= ptr_d;
		pend_addr_q <= pend_addr_d;
		ok_q        <= ok_d;
		fk_q        <= fk_d;
		fv_q        <= fv_d;
	end

	// next state, memory control and result
	always_comb begin
		state_d     = state_q;
		ptr_d       = ptr_q;
		pend_d      = 1'b0;
		pend_addr_d = pend_addr_q;
		count_d     = count_q;
		ok_d        = ok_q;
		fk_d        = fk_q;
		fv_d        = fv_q;
		rd_en       = 1'b0;
		rd_addr     = ptr_q[AW-1:0];
		wr_en       = 1'b0;
		wr_addr     = pend_addr_q;
		wr_key      = key_q;
		wr_value    = val_q;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ok_d  = 1'b0;
					fk_d  = '0;
					fv_d  = '0;
					ptr_d = '0;
					case (action) inside
						ACT_INSERT, ACT_UPDATE, ACT_UPSERT, ACT_ERASE, ACT_LOOKUP:
							state_d = ST_SCAN;
						ACT_READ: state_d = ST_RDIDX;
						default:  state_d = ST_DONE;
					endcase
				end
			end

			ST_SCAN: begin
				if (hit) begin
					// key present at pend_addr_q
					state_d = ST_DONE;
					case (act_q) inside
						ACT_UPDATE, ACT_UPSERT: begin
							wr_en = 1'b1;
							ok_d  = 1'b1;
						end
						ACT_ERASE: begin
							ok_d    = 1'b1;
							ptr_d   = CW'(pend_addr_q) + CW'(1);
							state_d = ST_SHIFT;
						end
						ACT_LOOKUP: begin
							ok_d = 1'b1;
							fv_d = rd_value;
						end
						default: ;
					endcase
				end else if (ptr_q < count_q) begin
					// advance the search one entry
					rd_en       = 1'b1;
					pend_d      = 1'b1;
					pend_addr_d = ptr_q[AW-1:0];
					ptr_d       = ptr_q + CW'(1);
				end else if (!pend_q) begin
					// key absent
					state_d = ST_DONE;
					case (act_q) inside
						ACT_INSERT, ACT_UPSERT: begin
							if (!full) begin
								wr_en   = 1'b1;
								wr_addr = count_q[AW-1:0];
								count_d = count_q + CW'(1);
								ok_d    = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end

			ST_SHIFT: begin
				// move the pair read last cycle down one place
				if (pend_q) begin
					wr_en    = 1'b1;
					wr_addr  = pend_addr_q - AW'(1);
					wr_key   = rd_key;
					wr_value = rd_value;
				end
				if (ptr_q < count_q) begin
					rd_en       = 1'b1;
					pend_d      = 1'b1;
					pend_addr_d = ptr_q[AW-1:0];
					ptr_d       = ptr_q + CW'(1);
				end else if (!pend_q) begin
					count_d = count_q - CW'(1);
					state_d = ST_DONE;
				end
			end

			ST_RDIDX: begin
				if (idx_ext < LW'(count_q)) begin
					rd_en   = 1'b1;
					rd_addr = idx_ext[AW-1:0];
					state_d = ST_RDWAIT;
				end else begin
					state_d = ST_DONE;
				end
			end

			ST_RDWAIT: begin
				ok_d    = 1'b1;
				fk_d    = rd_key;
				fv_d    = rd_value;
				state_d = ST_DONE;
			end

			ST_DONE: begin
				state_d = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = (state_q == ST_DONE);
	assign ok          = ok_q;
	assign found_key   = fk_q;
	assign found_value = fv_q;
	assign count       = count_q;

endmodule

@@ rtl/core/key_value_table_unit.sv @@
// Fixed-capacity key/value table, pairs kept in insertion order. A request
// is taken when start is high and busy is low; its one result appears on
// ok, found_key, found_value and entry_count for exactly one cycle with done
// high, and the receiver cannot stall it. Every keyed action searches the
// held pairs one per cycle through a single read port of the pair memory,
// stopping at the key or, when the key is absent, after the last pair;
// erase then moves each later pair down one place per cycle. Read at
// index reads the pair at that index; an index at or past the entry count
// and an unused action end the request without a read. The user must see
// that capacity is written through cfg_write/cfg_data only while the
// block is idle; the block itself does not enforce it.
module key_value_table_unit #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [kvt_pkg::CAP_W-1:0]     cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic [kvt_pkg::ACTION_W-1:0]  action,
	input  logic [KEY_BITS-1:0]           key,
	input  logic [VALUE_BITS-1:0]         value,
	input  logic [kvt_pkg::INDEX_W-1:0]   index,
	output logic                          done,
	output logic                          ok,
	output logic [KEY_BITS-1:0]           found_key,
	output logic [VALUE_BITS-1:0]         found_value,
	output logic [kvt_pkg::COUNT_W-1:0]   entry_count
);

	import kvt_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	logic [CAP_W-1:0]      cap_q;
	logic [CW-1:0]         count;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_value;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [KEY_BITS-1:0]   wr_key;
	logic [VALUE_BITS-1:0] wr_value;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_write) begin
			cap_q <= cfg_data;
		end
	end

	kvt_seq #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS),
		.AW         (AW),
		.CW         (CW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.key         (key),
		.value       (value),
		.index       (index),
		.capacity    (cap_q),
		.busy        (busy),
		.done        (done),
		.ok          (ok),
		.found_key   (found_key),
		.found_value (found_value),
		.count       (count),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_key      (rd_key),
		.rd_value    (rd_value),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_key      (wr_key),
		.wr_value    (wr_value)
	);

	kvt_store #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS),
		.AW         (AW)
	) u_store (
		.clk      (clk),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_key   (rd_key),
		.rd_value (rd_value),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_key   (wr_key),
		.wr_value (wr_value)
	);

	assign entry_count = COUNT_W'(count);

endmodule
